[rtl/core/pis_pkg.sv]
package pis_pkg;
  localparam int PID_W = 4;
  localparam int IDX_W = 6;
  localparam int DUR_W = 16;
  localparam int PRI_W = 8;
  localparam int TIME_W = 32;
  localparam int CNT_W = 7;
  localparam int QC_W = 5;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ARRIVE = 2'd1,
    OP_RUN    = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic                    valid;
    logic [PID_W-1:0]        pid;
    logic [PRI_W-1:0]        prio;
    logic [TIME_W-1:0]       arr;
  } entry_t;

  typedef struct packed {
    logic             insert;
    logic             pop;
    entry_t           ins;
  } qctl_t;
endpackage

[rtl/core/pis_cell.sv]
module pis_cell (
  input  logic            clk,
  input  logic            rst,
  input  pis_pkg::qctl_t  ctl,
  input  pis_pkg::entry_t left,
  input  logic            left_after,
  input  pis_pkg::entry_t right,
  output pis_pkg::entry_t held,
  output logic            after
);
  import pis_pkg::*;

  entry_t held_next;

  always_comb begin
    after = held.valid && ((held.prio > ctl.ins.prio) ||
            (held.prio == ctl.ins.prio && held.arr > ctl.ins.arr));
  end

  always_comb begin
    held_next = held;
    if (ctl.pop) begin
      held_next = right;
    end else if (ctl.insert) begin
      if (after) begin
        held_next = left_after ? left : ctl.ins;
      end else if (!held.valid) begin
        held_next = left_after ? left : (left.valid ? ctl.ins : held);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held.valid <= 1'b0;
    end else begin
      held.valid <= held_next.valid;
    end
    held.pid  <= held_next.pid;
    held.prio <= held_next.prio;
    held.arr  <= held_next.arr;
  end
endmodule

[rtl/core/pis_queue.sv]
module pis_queue #(
  parameter int MAX_PROCS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  pis_pkg::qctl_t          ctl,
  output pis_pkg::entry_t         head,
  output logic [MAX_PROCS-1:0]    hit
);
  import pis_pkg::*;

  entry_t held [MAX_PROCS];
  logic   after [MAX_PROCS];
  entry_t lft [MAX_PROCS];
  logic   lfa [MAX_PROCS];
  entry_t rgt [MAX_PROCS];

  genvar g;
  generate
    for (g = 0; g < MAX_PROCS; g++) begin : g_cell
      if (g == 0) begin : g_first
        assign lft[g] = '{valid: 1'b1, pid: '0, prio: '0, arr: '0};
        assign lfa[g] = 1'b0;
      end else begin : g_rest
        assign lft[g] = held[g-1];
        assign lfa[g] = after[g-1];
      end
      if (g == MAX_PROCS - 1) begin : g_last
        assign rgt[g] = '0;
      end else begin : g_mid
        assign rgt[g] = held[g+1];
      end
      assign hit[g] = held[g].valid && held[g].pid == ctl.ins.pid;
      pis_cell u_cell (
        .clk(clk), .rst(rst), .ctl(ctl), .left(lft[g]), .left_after(lfa[g]),
        .right(rgt[g]), .held(held[g]), .after(after[g])
      );
    end
  endgenerate

  assign head = held[0];
endmodule

[rtl/core/priority_instruction_scheduler.sv]
// Preemptive priority scheduler. The ready queue is a row of MAX_PROCS cells
// that shift together for a sorted insert or a head retire. Each item passes
// through an accept state, a read state for the process tables and the
// duration memory together, an update state and an output state; the
// registered read of the duration memory makes the read state needed. One
// result item is given per input item; the next input is taken while the
// previous result still waits on the output register, and the next result
// then holds in its output state until that register is free.
module priority_instruction_scheduler #(
  parameter int MAX_PROCS = 16,
  parameter int MAX_INSTR = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // opcode, process_id, instr_index, duration, priority_req, arrival,
  // instr_count
  input  logic [79:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // ran_process, ran_index, time_now, finished, turnaround, waiting,
  // queue_count, status
  output logic [119:0] m_tdata
);
  import pis_pkg::*;

  localparam int SW = $clog2(MAX_PROCS);
  localparam int IW = (MAX_INSTR > 1) ? $clog2(MAX_INSTR) : 1;
  localparam int CW = $clog2(MAX_INSTR + 1);
  localparam int QW = $clog2(MAX_PROCS + 1);
  localparam int AW = $clog2(MAX_PROCS * MAX_INSTR);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_EXEC = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state;
  logic [1:0]        op;
  logic [PID_W-1:0]  pid;
  logic [IDX_W-1:0]  idx;
  logic [DUR_W-1:0]  dur;
  logic [PRI_W-1:0]  prio;
  logic [TIME_W-1:0] arr;
  logic [CNT_W-1:0]  cnt;

  logic [TIME_W-1:0] sysclk;
  logic [QW-1:0]     qcount;

  logic [TIME_W-1:0] p_arr  [MAX_PROCS];
  logic [CW-1:0]     p_next [MAX_PROCS];
  logic [CW-1:0]     p_tot  [MAX_PROCS];
  logic [TIME_W-1:0] p_exec [MAX_PROCS];
  logic [DUR_W-1:0]  itime  [MAX_PROCS*MAX_INSTR];

  logic [SW-1:0]     hslot;
  logic [IW-1:0]     k;
  logic [CW-1:0]     tot;
  logic [TIME_W-1:0] harr, hexec;
  logic [DUR_W-1:0]  d;

  qctl_t             ctl;
  entry_t            head;
  logic [MAX_PROCS-1:0] hit;

  logic [119:0] obuf;
  logic         ovalid;
  logic [119:0] res, res_next;

  pis_queue #(.MAX_PROCS(MAX_PROCS)) u_queue (
    .clk(clk), .rst(rst), .ctl(ctl), .head(head), .hit(hit)
  );

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = ovalid;
  assign m_tdata  = obuf;

  logic pid_ok, idx_ok;
  assign pid_ok = {28'd0, pid} < 32'(MAX_PROCS);
  assign idx_ok = {26'd0, idx} < 32'(MAX_INSTR);

  logic [CW-1:0] cnt_c;
  always_comb begin
    if (cnt == '0) cnt_c = CW'(1);
    else if ({25'd0, cnt} > 32'(MAX_INSTR)) cnt_c = CW'(MAX_INSTR);
    else cnt_c = CW'(cnt);
  end

  logic arrive_go, full, queued;
  assign queued = |hit;
  assign full   = 32'(qcount) >= 32'(MAX_PROCS);
  assign arrive_go = op == OP_ARRIVE && pid_ok && !queued && !full;

  logic [TIME_W-1:0] new_clk, new_exec;
  logic fin;
  assign new_clk  = sysclk + TIME_W'(d);
  assign new_exec = hexec + TIME_W'(d);
  assign fin      = {{(32-CW){1'b0}}, CW'(k) + CW'(1)} >= {{(32-CW){1'b0}}, tot};

  always_comb begin
    ctl = '0;
    ctl.ins = '{valid: 1'b1, pid: pid, prio: prio, arr: arr};
    if (state == S_EXEC) begin
      ctl.insert = arrive_go;
      ctl.pop    = op == OP_RUN && qcount != '0 && fin;
    end
  end

  always_comb begin
    res_next = '0;
    if (arrive_go) begin
      res_next[41:10]   = (qcount == '0 && arr > sysclk) ? arr : sysclk;
      res_next[111:107] = 5'(qcount + QW'(1));
    end else if (op == OP_RUN && qcount != '0) begin
      res_next[3:0]   = 4'(hslot);
      res_next[9:4]   = 6'(k);
      res_next[41:10] = new_clk;
      res_next[42]    = fin;
      if (fin) begin
        res_next[74:43]  = new_clk - harr;
        res_next[106:75] = new_clk - harr - new_exec;
      end
      res_next[111:107] = 5'(fin ? qcount - QW'(1) : qcount);
    end else begin
      res_next[41:10]   = sysclk;
      res_next[111:107] = 5'(qcount);
      if (op == OP_RUN) res_next[113:112] = ST_EMPTY;
      else if (op == OP_ARRIVE && pid_ok && !queued && full)
        res_next[113:112] = ST_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_tvalid) begin
      op   <= s_tdata[1:0];
      pid  <= s_tdata[5:2];
      idx  <= s_tdata[11:6];
      dur  <= s_tdata[27:12];
      prio <= s_tdata[35:28];
      arr  <= s_tdata[67:36];
      cnt  <= s_tdata[74:68];
    end
    if (state == S_READ) begin
      hslot <= SW'(head.pid);
      k     <= IW'(p_next[SW'(head.pid)]);
      tot   <= p_tot[SW'(head.pid)];
      harr  <= p_arr[SW'(head.pid)];
      hexec <= p_exec[SW'(head.pid)];
    end
    if (state == S_READ && op == OP_LOAD && pid_ok && idx_ok) begin
      itime[AW'(SW'(pid) * MAX_INSTR + IW'(idx))] <= dur;
    end
    d <= itime[AW'(SW'(head.pid) * MAX_INSTR + IW'(p_next[SW'(head.pid)]))];
    if (state == S_EXEC) begin
      if (arrive_go) begin
        p_arr[SW'(pid)]  <= arr;
        p_next[SW'(pid)] <= '0;
        p_tot[SW'(pid)]  <= cnt_c;
        p_exec[SW'(pid)] <= '0;
      end else if (op == OP_RUN && qcount != '0) begin
        p_exec[hslot] <= new_exec;
        p_next[hslot] <= CW'(k) + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      sysclk <= '0;
      qcount <= '0;
      ovalid <= 1'b0;
    end else begin
      if (state == S_OUT && (!ovalid || m_tready)) ovalid <= 1'b1;
      else if (m_tready) ovalid <= 1'b0;
      unique case (state)
        S_IDLE: if (s_tvalid) state <= S_READ;
        S_READ: state <= S_EXEC;
        S_EXEC: begin
          res <= res_next;
          if (arrive_go) begin
            if (qcount == '0 && arr > sysclk) sysclk <= arr;
            qcount <= qcount + QW'(1);
          end else if (op == OP_RUN && qcount != '0) begin
            sysclk <= new_clk;
            if (fin) qcount <= qcount - QW'(1);
          end
          state <= S_OUT;
        end
        S_OUT: if (!ovalid || m_tready) begin
          obuf  <= res;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_qmax: assert property (@(posedge clk) disable iff (rst)
    32'(qcount) <= 32'(MAX_PROCS)) else $error("queue count over range");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    ovalid && !m_tready |=> ovalid) else $error("result dropped");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == S_READ) else $error("accept lost");
`endif
endmodule

[tb/priority_instruction_scheduler_tb.sv]
module priority_instruction_scheduler_tb;
  import pis_pkg::*;

  localparam int NPROC = 16;
  localparam int NINSTR = 64;
  localparam int STALL_LIMIT = 4000;
  localparam int ITEM_TARGET = 1950;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  pid;
    logic [5:0]  idx;
    logic [15:0] dur;
    logic [7:0]  prio;
    logic [31:0] arr;
    logic [6:0]  cnt;
  } sched_cmd_t;

  // highest field first, so the struct matches m_tdata[113:0]
  typedef struct packed {
    logic [1:0]  stat;
    logic [4:0]  qcount;
    logic [31:0] wait_t;
    logic [31:0] turn;
    logic        fin;
    logic [31:0] now;
    logic [5:0]  ran_idx;
    logic [3:0]  ran_pid;
  } sched_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [79:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [119:0] m_tdata;

  priority_instruction_scheduler u_top (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #10 clk = ~clk;

  // scheduler shadow state
  logic [3:0]  q_order [NPROC];
  int          q_len;
  logic [7:0]  p_prio [NPROC];
  logic [31:0] p_arr [NPROC];
  int          p_next [NPROC];
  int          p_total [NPROC];
  logic [31:0] p_exec [NPROC];
  logic [15:0] dur_mem [NPROC*NINSTR];
  bit          dur_set [NPROC*NINSTR];
  logic [31:0] sys_time;

  sched_res_t  exp_mem [4096];
  int          exp_wr = 0;
  int          exp_rd = 0;
  int          sent = 0;
  int          errors = 0;
  int          idle_cycles = 0;
  int          out_wait = 0;
  bit          gaps_on = 1'b1;

  function automatic bit is_queued(logic [3:0] pid);
    for (int i = 0; i < q_len; i++) if (q_order[i] == pid) return 1'b1;
    return 1'b0;
  endfunction

  function automatic sched_res_t schedule_step(sched_cmd_t c);
    sched_res_t r;
    int pos, cnt, k, h;
    logic [15:0] d;
    r = '0;
    r.stat = ST_OK;
    case (op_t'(c.op))
      OP_LOAD: begin
        dur_mem[c.pid*NINSTR + c.idx] = c.dur;
        dur_set[c.pid*NINSTR + c.idx] = 1'b1;
      end
      OP_ARRIVE: begin
        if (!is_queued(c.pid)) begin
          if (q_len >= NPROC) begin
            r.stat = ST_FULL;
          end else begin
            cnt = (c.cnt == 0) ? 1 : (c.cnt > NINSTR ? NINSTR : c.cnt);
            if (q_len == 0 && c.arr > sys_time) sys_time = c.arr;
            p_prio[c.pid] = c.prio;
            p_arr[c.pid] = c.arr;
            p_next[c.pid] = 0;
            p_total[c.pid] = cnt;
            p_exec[c.pid] = '0;
            for (pos = 0; pos < q_len; pos++) begin
              h = q_order[pos];
              if (p_prio[h] > c.prio || (p_prio[h] == c.prio && p_arr[h] > c.arr)) break;
            end
            for (int i = q_len; i > pos; i--) q_order[i] = q_order[i-1];
            q_order[pos] = c.pid;
            q_len++;
          end
        end
      end
      OP_RUN: begin
        if (q_len == 0) begin
          r.stat = ST_EMPTY;
        end else begin
          h = q_order[0];
          k = p_next[h] % NINSTR;
          d = dur_mem[h*NINSTR + k];
          r.ran_pid = 4'(h);
          r.ran_idx = 6'(k);
          sys_time += d;
          p_exec[h] += d;
          p_next[h] = k + 1;
          if (k + 1 >= p_total[h]) begin
            r.fin = 1'b1;
            r.turn = sys_time - p_arr[h];
            r.wait_t = r.turn - p_exec[h];
            for (int i = 1; i < q_len; i++) q_order[i-1] = q_order[i];
            q_len--;
          end
        end
      end
      default: ;
    endcase
    r.now = sys_time;
    r.qcount = 5'(q_len);
    return r;
  endfunction

  // true when running the head would hit an unloaded duration
  function automatic bit run_unsafe();
    int h;
    if (q_len == 0) return 1'b0;
    h = q_order[0];
    return !dur_set[h*NINSTR + (p_next[h] % NINSTR)];
  endfunction

  task automatic send_item(sched_cmd_t c);
    int gap;
    gap = gaps_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata <= {5'd0, c.cnt, c.arr, c.prio, c.dur, c.idx, c.pid, c.op};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    exp_mem[exp_wr[11:0]] = schedule_step(c);
    exp_wr++;
    sent++;
  endtask

  function automatic sched_cmd_t make_cmd(op_t op, int pid, int idx, int dur, int prio,
                                          logic [31:0] arr, int cnt);
    sched_cmd_t c;
    c.op = op; c.pid = 4'(pid); c.idx = 6'(idx); c.dur = 16'(dur);
    c.prio = 8'(prio); c.arr = arr; c.cnt = 7'(cnt);
    return c;
  endfunction

  function automatic sched_cmd_t rand_cmd(op_t op);
    sched_cmd_t c;
    logic [95:0] bits;
    bits = {$urandom, $urandom, $urandom};
    c = bits[74:0];
    c.op = op;
    return c;
  endfunction

  task automatic load_all(int pid, int n);
    for (int i = 0; i < n; i++)
      send_item(make_cmd(OP_LOAD, pid, i, $urandom_range(0, 65535), 0, 0, 0));
  endtask

  task automatic test_directed();
    send_item(make_cmd(OP_RUN, 0, 0, 0, 0, 0, 0));
    send_item(make_cmd(OP_NONE, 15, 63, 65535, 255, 32'hFFFF_FFFF, 127));
    send_item(make_cmd(OP_LOAD, 15, 63, 65535, 0, 0, 0));
    send_item(make_cmd(OP_LOAD, 15, 0, 65535, 0, 0, 0));
    send_item(make_cmd(OP_LOAD, 0, 0, 0, 0, 0, 0));
    send_item(make_cmd(OP_LOAD, 1, 0, 7, 0, 0, 0));
    send_item(make_cmd(OP_ARRIVE, 15, 0, 0, 255, 32'hFFFF_FFF0, 0));
    send_item(make_cmd(OP_ARRIVE, 15, 0, 0, 0, 0, 3));
    send_item(make_cmd(OP_ARRIVE, 0, 0, 0, 0, 32'hFFFF_FFF0, 1));
    send_item(make_cmd(OP_ARRIVE, 1, 0, 0, 255, 32'hFFFF_FFF0, 1));
    send_item(make_cmd(OP_RUN, 0, 0, 0, 0, 0, 0));
    send_item(make_cmd(OP_RUN, 0, 0, 0, 0, 0, 0));
    send_item(make_cmd(OP_RUN, 0, 0, 0, 0, 0, 0));
    send_item(make_cmd(OP_RUN, 0, 0, 0, 0, 0, 0));
    load_all(2, 64);
    send_item(make_cmd(OP_ARRIVE, 2, 0, 0, 128, 0, 127));
    repeat (64) send_item(make_cmd(OP_RUN, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_full_queue();
    for (int p = 0; p < NPROC; p++) load_all(p, 2);
    for (int p = 0; p < NPROC; p++)
      send_item(make_cmd(OP_ARRIVE, p, 0, 0, $urandom_range(0, 3), sys_time, 2));
    send_item(make_cmd(OP_ARRIVE, 3, 0, 0, 0, 0, 1));
    while (q_len > 0) send_item(make_cmd(OP_RUN, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_random(int n);
    sched_cmd_t c;
    int p, roll;
    for (int i = 0; i < n && sent < ITEM_TARGET; i++) begin
      if (i % 400 == 200) gaps_on = 1'b0;
      if (i % 400 == 300) gaps_on = 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
        c = rand_cmd(OP_LOAD);
        if ($urandom_range(0, 3) != 0) c.idx = 6'($urandom_range(0, 7));
      end else if (roll < 55) begin
        c = rand_cmd(OP_ARRIVE);
        if ($urandom_range(0, 3) != 0) c.cnt = 7'($urandom_range(0, 8));
        if ($urandom_range(0, 3) != 0) c.prio = 8'($urandom_range(0, 7));
        if ($urandom_range(0, 2) != 0) c.arr = sys_time + $urandom_range(0, 50);
        for (int k = 0; k < c.cnt && k < NINSTR; k++)
          if (!dur_set[c.pid*NINSTR + k])
            send_item(make_cmd(OP_LOAD, c.pid, k, $urandom, 0, 0, 0));
      end else if (roll < 97) begin
        c = rand_cmd(OP_RUN);
        if (run_unsafe()) begin
          p = q_order[0];
          send_item(make_cmd(OP_LOAD, p, p_next[p] % NINSTR, $urandom, 0, 0, 0));
        end
      end else begin
        c = rand_cmd(OP_NONE);
      end
      send_item(c);
    end
  endtask

  // output side
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      out_wait <= 0;
    end else if (m_tvalid && m_tready) begin
      m_tready <= 1'b0;
      out_wait <= gaps_on ? $urandom_range(0, 14) : 0;
    end else if (m_tvalid && out_wait > 0) begin
      out_wait <= out_wait - 1;
    end else if (out_wait == 0) begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    sched_res_t got, exp_r;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (m_tvalid && m_tready) begin
        got = m_tdata[113:0];
        if (exp_rd == exp_wr) begin
          $display("%0t: unexpected result %h", $time, m_tdata);
          errors++;
        end else begin
          exp_r = exp_mem[exp_rd[11:0]];
          exp_rd++;
          if (got !== exp_r) begin
            $display("%0t: mismatch expected %h actual %h", $time, exp_r, got);
            errors++;
          end
        end
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    q_len = 0;
    sys_time = '0;
    foreach (dur_set[i]) dur_set[i] = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_queue();
    test_random(ITEM_TARGET);
    s_tvalid <= 1'b0;
    while (exp_rd != exp_wr) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && exp_rd == exp_wr) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
